// File: hdl/ptcm_pkg.sv
// Package for the position trigram character model.
// Holds operation codes, status codes and symbol constants; no dependencies.
`default_nettype none
package ptcm_pkg;
   localparam int NUM_SYMBOLS = 27;
   localparam logic [4:0] START_SYMBOL = 5'd26;
   localparam logic [4:0] END_SYMBOL = 5'd26;
   localparam logic [4:0] LAST_LETTER = 5'd25;

   typedef enum logic [1:0] {
      OP_TRAIN_LETTER = 2'd0,
      OP_TRAIN_END    = 2'd1,
      OP_SAMPLE       = 2'd2,
      OP_NONE         = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_SATURATED = 2'd2,
      ST_UNUSED    = 2'd3
   } status_type;
endpackage
`default_nettype wire

// File: hdl/ptcm_if.sv
// Valid/ready channel interface carrying the request or response payload.
// Depends on nothing; payload widths are fixed by the field list.
`default_nettype none
interface ptcm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [4:0] letter;
   logic [30:0] random_value;
   modport source (output valid, output operation, output letter, output random_value,
                   input ready);
   modport sink (input valid, input operation, input letter, input random_value,
                 output ready);
endinterface

interface ptcm_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] sampled_symbol;
   logic [1:0] status;
   modport source (output valid, output sampled_symbol, output status, input ready);
   modport sink (input valid, input sampled_symbol, input status, output ready);
endinterface
`default_nettype wire

// File: hdl/ptcm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ptcm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write or read one entry a cycle
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// File: hdl/ptcm_mod_unit.sv
// Restoring remainder unit: one quotient bit a cycle, 31 steps, done with the result.
// Self-contained; the count width comes in as a parameter.
`default_nettype none
module ptcm_mod_unit #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [30:0]           dividend,
   input  wire logic [COUNT_BITS-1:0] divisor,
   output logic                       done,
   output logic      [COUNT_BITS-1:0] remainder
);
   logic [30:0]         dividend_ff, dividend_in;
   logic [COUNT_BITS:0] rem_ff, rem_in;
   logic [4:0]          count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [COUNT_BITS:0] trial;

   // shift in the next dividend bit and subtract where it fits
   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      trial       = {rem_ff[COUNT_BITS-1:0], dividend_ff[30]};
      if (start) begin
         dividend_in = dividend;
         rem_in      = '0;
         count_in    = 5'd0;
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[29:0], 1'b0};
         if (trial >= {1'b0, divisor}) rem_in = trial - {1'b0, divisor};
         else rem_in = trial;
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd30) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      count_ff    <= count_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[COUNT_BITS-1:0];
endmodule
`default_nettype wire

// File: hdl/position_trigram_char_model.sv
// Top level of the position trigram character model: sequencer, count stores.
// Depends on ptcm_pkg, ptcm_if, ptcm_ram and ptcm_mod_unit.
//
// Usage: requests arrive on req (operation, letter, random_value); one
// response per request leaves on rsp (sampled_symbol, status). The block
// takes one request at a time; req.ready is high only when it is idle.
// A train steps through read total, read count, write back and load output;
// an ignored item goes straight to load output, and a sample of an empty
// context, like a saturated train, reads the total first. A sample runs
// the remainder unit (31 quotient bits, one per cycle, plus its done flag),
// then walks the counts, up to 27, until their running sum exceeds the
// remainder. The next request can be taken in the same cycle as rsp.valid rises.
// After reset the block sweeps both count stores to zero, one entry per
// cycle, across all 27*27*MAX_POSITIONS*27 counts (157464 at defaults); req.ready
// stays low meanwhile. Both contexts return to the start marker at position
// zero. A finished response is held in the output register until taken; with
// the receiver stalled, one further request is worked on and then waits, and
// no more requests are accepted until the output register empties.
`default_nettype none
module position_trigram_char_model #(
   parameter int MAX_POSITIONS = 8,
   parameter int COUNT_BITS    = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   ptcm_req_if.sink   req,
   ptcm_rsp_if.source rsp
);
   import ptcm_pkg::*;

   localparam int NUM_CTX   = NUM_SYMBOLS * NUM_SYMBOLS * MAX_POSITIONS;
   localparam int NUM_CNT   = NUM_CTX * NUM_SYMBOLS;
   localparam int CTX_BITS  = $clog2(NUM_CTX);
   localparam int CNT_BITS  = $clog2(NUM_CNT);
   localparam int POS_BITS  = $clog2(MAX_POSITIONS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(MAX_POSITIONS - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_TOTAL_RD, S_TOTAL_WAIT, S_TRAIN_RD, S_TRAIN_WAIT,
      S_TRAIN_WR, S_MOD, S_WALK_RD, S_WALK_WAIT, S_WALK, S_RESP
   } state_type;

   state_type state_ff;
   logic [CNT_BITS-1:0]   clear_ff;
   logic [1:0]            op_ff;
   logic [4:0]            sym_ff;
   logic [30:0]           rnd_ff;
   logic [4:0]            t_old_ff, t_new_ff, g_old_ff, g_new_ff;
   logic [POS_BITS-1:0]   t_pos_ff, g_pos_ff;
   logic [CTX_BITS-1:0]   ctx_ff;
   logic [COUNT_BITS-1:0] total_ff, r_ff;
   logic [COUNT_BITS:0]   sum_ff;
   logic [4:0]            walk_ff;
   logic [4:0]            res_sym_ff;
   logic [1:0]            res_st_ff;
   logic                  rsp_valid_ff;
   logic [4:0]            rsp_sym_ff;
   logic [1:0]            rsp_st_ff;

   // memory ports
   logic                  tot_we, cnt_we;
   logic [CTX_BITS-1:0]   tot_addr;
   logic [CNT_BITS-1:0]   cnt_addr;
   logic [COUNT_BITS-1:0] tot_wd, cnt_wd, tot_rd, cnt_rd;
   logic                  mod_start, mod_done;
   logic [COUNT_BITS-1:0] mod_rem;
   logic [CNT_BITS-1:0]   cnt_base;

   ptcm_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_CTX)) u_totals (
      .clock(clock), .wr_en(tot_we), .addr(tot_addr), .wr_data(tot_wd), .rd_data(tot_rd));
   ptcm_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_CNT)) u_counts (
      .clock(clock), .wr_en(cnt_we), .addr(cnt_addr), .wr_data(cnt_wd), .rd_data(cnt_rd));
   ptcm_mod_unit #(.COUNT_BITS(COUNT_BITS)) u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(rnd_ff),
      .divisor(total_ff), .done(mod_done), .remainder(mod_rem));

   // context index of a symbol pair and position
   function automatic logic [CTX_BITS-1:0] ctx_of(input logic [4:0] o, input logic [4:0] n,
                                                  input logic [POS_BITS-1:0] p);
      logic [CTX_BITS+5:0] v;
      v = ((CTX_BITS+6)'(o) * (CTX_BITS+6)'(NUM_SYMBOLS) + (CTX_BITS+6)'(n))
          * (CTX_BITS+6)'(MAX_POSITIONS) + (CTX_BITS+6)'(p);
      return v[CTX_BITS-1:0];
   endfunction

   assign cnt_base = CNT_BITS'(ctx_ff) * CNT_BITS'(NUM_SYMBOLS);

   // drive memory ports from the state
   always_comb begin
      tot_we   = 1'b0;
      cnt_we   = 1'b0;
      tot_addr = ctx_ff;
      cnt_addr = cnt_base + CNT_BITS'(sym_ff);
      tot_wd   = total_ff + COUNT_BITS'(1);
      cnt_wd   = cnt_rd + COUNT_BITS'(1);
      mod_start = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cnt_we   = 1'b1;
            cnt_addr = clear_ff;
            cnt_wd   = '0;
            tot_we   = (clear_ff < CNT_BITS'(NUM_CTX));
            tot_addr = clear_ff[CTX_BITS-1:0];
            tot_wd   = '0;
         end
         S_TRAIN_WR: begin
            cnt_we = 1'b1;
            tot_we = 1'b1;
         end
         S_MOD: mod_start = 1'b0;
         // hold the walk address until the count is in hand
         S_WALK_RD, S_WALK_WAIT: cnt_addr = cnt_base + CNT_BITS'(walk_ff);
         default: ;
      endcase
      if (state_ff == S_TOTAL_WAIT && op_ff == OP_SAMPLE && tot_rd != '0) mod_start = 1'b1;
   end

   // sequencer: state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         t_old_ff <= START_SYMBOL; t_new_ff <= START_SYMBOL; t_pos_ff <= '0;
         g_old_ff <= START_SYMBOL; g_new_ff <= START_SYMBOL; g_pos_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clear_ff <= clear_ff + CNT_BITS'(1);
               if (clear_ff == CNT_BITS'(NUM_CNT - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req.valid) begin
               op_ff  <= req.operation;
               rnd_ff <= req.random_value;
               sym_ff <= (req.operation == OP_TRAIN_END) ? END_SYMBOL : req.letter;
               res_sym_ff <= 5'd0;
               res_st_ff  <= ST_OK;
               if (req.operation == OP_SAMPLE) begin
                  ctx_ff   <= ctx_of(g_old_ff, g_new_ff, g_pos_ff);
                  state_ff <= S_TOTAL_RD;
               end else if (req.operation == OP_TRAIN_END ||
                            (req.operation == OP_TRAIN_LETTER && req.letter <= LAST_LETTER)) begin
                  ctx_ff   <= ctx_of(t_old_ff, t_new_ff, t_pos_ff);
                  state_ff <= S_TOTAL_RD;
               end else begin
                  state_ff <= S_RESP;
               end
            end
            S_TOTAL_RD: state_ff <= S_TOTAL_WAIT;
            S_TOTAL_WAIT: begin
               total_ff <= tot_rd;
               if (op_ff == OP_SAMPLE) begin
                  res_sym_ff <= END_SYMBOL;
                  if (tot_rd == '0) begin
                     res_st_ff <= ST_EMPTY;
                     g_old_ff <= START_SYMBOL; g_new_ff <= START_SYMBOL; g_pos_ff <= '0;
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_MOD;
                  end
               end else begin
                  // advance the training context whether or not the count lands
                  if (sym_ff == END_SYMBOL) begin
                     t_old_ff <= START_SYMBOL; t_new_ff <= START_SYMBOL; t_pos_ff <= '0;
                  end else begin
                     t_old_ff <= t_new_ff; t_new_ff <= sym_ff;
                     if (t_pos_ff != LAST_POS) t_pos_ff <= t_pos_ff + POS_BITS'(1);
                  end
                  if (tot_rd == COUNT_MAX) begin
                     res_st_ff <= ST_SATURATED;
                     state_ff  <= S_RESP;
                  end else begin
                     state_ff <= S_TRAIN_RD;
                  end
               end
            end
            S_TRAIN_RD: state_ff <= S_TRAIN_WAIT;
            S_TRAIN_WAIT: state_ff <= S_TRAIN_WR;
            S_TRAIN_WR: state_ff <= S_RESP;
            S_MOD: if (mod_done) begin
               r_ff     <= mod_rem;
               sum_ff   <= '0;
               walk_ff  <= 5'd0;
               state_ff <= S_WALK_RD;
            end
            S_WALK_RD: state_ff <= S_WALK_WAIT;
            S_WALK_WAIT: state_ff <= S_WALK;
            S_WALK: begin
               // r <= sum + count, with r taken as remainder + 1
               if ({1'b0, r_ff} < sum_ff + (COUNT_BITS+1)'(cnt_rd)) begin
                  res_sym_ff <= walk_ff;
                  if (walk_ff == END_SYMBOL) begin
                     g_old_ff <= START_SYMBOL; g_new_ff <= START_SYMBOL; g_pos_ff <= '0;
                  end else begin
                     g_old_ff <= g_new_ff; g_new_ff <= walk_ff;
                     if (g_pos_ff != LAST_POS) g_pos_ff <= g_pos_ff + POS_BITS'(1);
                  end
                  state_ff <= S_RESP;
               end else if (walk_ff == END_SYMBOL) begin
                  g_old_ff <= START_SYMBOL; g_new_ff <= START_SYMBOL; g_pos_ff <= '0;
                  state_ff <= S_RESP;
               end else begin
                  sum_ff   <= sum_ff + (COUNT_BITS+1)'(cnt_rd);
                  walk_ff  <= walk_ff + 5'd1;
                  state_ff <= S_WALK_RD;
               end
            end
            // load the output register once it is free
            S_RESP: if (!rsp_valid_ff) begin
               rsp_valid_ff <= 1'b1;
               rsp_sym_ff   <= res_sym_ff;
               rsp_st_ff    <= res_st_ff;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready          = (state_ff == S_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.sampled_symbol = rsp_sym_ff;
   assign rsp.status         = rsp_st_ff;

   // rsp.valid never rises on the acceptance of a request
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !rsp_valid_ff || $past(rsp_valid_ff))
      else $error("response appeared on acceptance");
   // saturated responses come only from training and carry symbol zero
   a_train_symbol: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_st_ff == ST_SATURATED) |-> rsp_sym_ff == 5'd0)
      else $error("train response with a symbol");
   // empty status comes only with the end symbol
   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_st_ff == ST_EMPTY) |-> rsp_sym_ff == END_SYMBOL)
      else $error("empty status without end symbol");
endmodule
`default_nettype wire

// File: verif/ptcm_checker.sv
// Checker for the position trigram character model: watches both channels,
// predicts each response from its own count tables and compares field by field.
// Depends on ptcm_pkg and ptcm_if.
`default_nettype none
module ptcm_checker #(
   parameter int MAX_POSITIONS = 8,
   parameter int COUNT_BITS    = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   ptcm_req_if       req,
   ptcm_rsp_if       rsp,
   output int        failures,
   output int        awaited
);
   timeunit 1ns;
   timeprecision 1ps;
   import ptcm_pkg::*;

   localparam int NUM_CONTEXTS = NUM_SYMBOLS * NUM_SYMBOLS * MAX_POSITIONS;
   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

   typedef struct packed {
      logic [4:0] sampled_symbol;
      status_type status;
   } symbol_result;

   typedef struct {
      logic [4:0] older;
      logic [4:0] newer;
      int         position;
   } word_context;

   logic [COUNT_BITS-1:0] letter_counts [NUM_CONTEXTS*NUM_SYMBOLS];
   logic [COUNT_BITS-1:0] context_sums  [NUM_CONTEXTS];
   word_context           train_ctx;
   word_context           sample_ctx;
   symbol_result          awaited_symbols [$];

   function automatic int context_slot(word_context ctx);
      return (int'(ctx.older) * NUM_SYMBOLS + int'(ctx.newer)) * MAX_POSITIONS
             + ctx.position;
   endfunction

   // Move a context on by one symbol; end of word returns it to the start.
   function automatic word_context next_context(word_context ctx, logic [4:0] symbol);
      word_context moved;
      moved = ctx;
      if (symbol >= END_SYMBOL) begin
         moved.older    = START_SYMBOL;
         moved.newer    = START_SYMBOL;
         moved.position = 0;
      end else begin
         moved.older = ctx.newer;
         moved.newer = symbol;
         if (ctx.position < MAX_POSITIONS - 1) moved.position = ctx.position + 1;
      end
      return moved;
   endfunction

   // Count one trained symbol unless the context total has saturated.
   function automatic status_type count_symbol(logic [4:0] symbol);
      int         slot;
      status_type outcome;
      slot    = context_slot(train_ctx);
      outcome = ST_OK;
      if (context_sums[slot] == COUNT_LIMIT) begin
         outcome = ST_SATURATED;
      end else begin
         letter_counts[slot*NUM_SYMBOLS + symbol] += 1'b1;
         context_sums[slot] += 1'b1;
      end
      train_ctx = next_context(train_ctx, symbol);
      return outcome;
   endfunction

   // Draw from the generation context by walking the running sum of counts.
   function automatic symbol_result draw_symbol(logic [30:0] random_value);
      int           slot;
      longint       target;
      longint       running;
      symbol_result drawn;
      slot                 = context_slot(sample_ctx);
      drawn.sampled_symbol = END_SYMBOL;
      drawn.status         = ST_OK;
      if (context_sums[slot] == 0) begin
         drawn.status = ST_EMPTY;
      end else begin
         target  = longint'(random_value) % longint'(context_sums[slot]) + 1;
         running = 0;
         for (int s = 0; s < NUM_SYMBOLS; s++) begin
            running += longint'(letter_counts[slot*NUM_SYMBOLS + s]);
            if (target <= running) begin
               drawn.sampled_symbol = 5'(s);
               break;
            end
         end
      end
      sample_ctx = next_context(sample_ctx, drawn.sampled_symbol);
      return drawn;
   endfunction

   function automatic symbol_result predict_symbol(op_type operation, logic [4:0] letter,
                                                   logic [30:0] random_value);
      symbol_result outcome;
      outcome = '{sampled_symbol: 5'd0, status: ST_OK};
      case (operation)
         OP_TRAIN_LETTER: begin
            if (letter <= LAST_LETTER) outcome.status = count_symbol(letter);
         end
         OP_TRAIN_END: begin
            outcome.status = count_symbol(END_SYMBOL);
         end
         OP_SAMPLE: begin
            outcome = draw_symbol(random_value);
         end
         default: begin
         end
      endcase
      return outcome;
   endfunction

   // Clear the tables once; reset is asserted only at the start of the run.
   initial begin
      foreach (letter_counts[i]) letter_counts[i] = '0;
      foreach (context_sums[i]) context_sums[i] = '0;
   end

   // Predict on each request transfer, compare on each response transfer.
   always @(posedge clock) begin
      symbol_result oldest;
      if (reset) begin
         train_ctx  = '{older: START_SYMBOL, newer: START_SYMBOL, position: 0};
         sample_ctx = '{older: START_SYMBOL, newer: START_SYMBOL, position: 0};
         awaited_symbols.delete();
         failures = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (awaited_symbols.size() == 0) begin
               $error("response transfer with none awaited: symbol %0d status %0d",
                      rsp.sampled_symbol, rsp.status);
               failures++;
            end else begin
               oldest = awaited_symbols.pop_front();
               if (rsp.sampled_symbol !== oldest.sampled_symbol) begin
                  $error("sampled_symbol: expected %0d, actual %0d",
                         oldest.sampled_symbol, rsp.sampled_symbol);
                  failures++;
               end
               if (rsp.status !== oldest.status) begin
                  $error("status: expected %0d, actual %0d", oldest.status, rsp.status);
                  failures++;
               end
            end
         end
         if (req.valid && req.ready)
            awaited_symbols = {awaited_symbols,
                               predict_symbol(op_type'(req.operation), req.letter,
                                              req.random_value)};
      end
      awaited = awaited_symbols.size();
   end
endmodule
`default_nettype wire

// File: verif/position_trigram_char_model_test.sv
// Top of the position trigram character model testbench: clock, reset, request
// stimulus, response back-pressure and verdict. Depends on ptcm_pkg, ptcm_if,
// ptcm_checker and the block itself.
`default_nettype none
module position_trigram_char_model_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ptcm_pkg::*;

   localparam int MAX_POSITIONS = 8;
   localparam int COUNT_BITS    = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   failures;
   int   awaited;
   bit   gaps_on = 1'b1;
   bit   hold_off_due = 1'b0;

   ptcm_req_if req ();
   ptcm_rsp_if rsp ();

   position_trigram_char_model #(
      .MAX_POSITIONS(MAX_POSITIONS),
      .COUNT_BITS   (COUNT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   ptcm_checker #(
      .MAX_POSITIONS(MAX_POSITIONS),
      .COUNT_BITS   (COUNT_BITS)
   ) checker_unit (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .failures(failures),
      .awaited (awaited)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Give up after a generous fixed time.
   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   // Drive the response ready: random stalls, one long hold-off on request.
   initial begin
      bit held_once;
      held_once = 1'b0;
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_due && !held_once) begin
            rsp.ready <= 1'b0;
            repeat (400) @(posedge clock);
            held_once = 1'b1;
         end
         rsp.ready <= !(gaps_on && $urandom_range(99) < 29);
      end
   end

   // Offer one request and hold it until the transfer.
   task automatic offer(op_type operation, logic [4:0] letter, logic [30:0] random_value);
      if (gaps_on && $urandom_range(99) < 29) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.operation    <= operation;
      req.letter       <= letter;
      req.random_value <= random_value;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic drain_responses();
      req.valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
   endtask

   // A word of random letters with samples mixed in, and some noise.
   task automatic offer_word();
      int length;
      length = $urandom_range(1, 11);
      for (int k = 0; k < length; k++) begin
         if ($urandom_range(99) < 35) offer(OP_SAMPLE, 5'($urandom), 31'($urandom));
         if ($urandom_range(99) < 8)
            offer($urandom_range(1) ? OP_NONE : OP_TRAIN_LETTER,
                  5'($urandom_range(26, 31)), 31'($urandom));
         offer(OP_TRAIN_LETTER, 5'($urandom_range(0, 25)), 31'($urandom));
      end
      if ($urandom_range(99) < 85) offer(OP_TRAIN_END, 5'($urandom), 31'($urandom));
   endtask

   initial begin
      req.valid        = 1'b0;
      req.operation    = OP_NONE;
      req.letter       = '0;
      req.random_value = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty context, range extremes, ignored items, short words.
      offer(OP_SAMPLE, 5'd0, 31'h7FFF_FFFF);
      offer(OP_NONE, 5'd31, 31'h7FFF_FFFF);
      offer(OP_TRAIN_LETTER, 5'd26, 31'd0);
      offer(OP_TRAIN_LETTER, 5'd31, 31'd0);
      offer(OP_TRAIN_LETTER, 5'd25, 31'd0);
      offer(OP_TRAIN_LETTER, 5'd0, 31'd0);
      offer(OP_TRAIN_END, 5'd31, 31'd0);
      offer(OP_TRAIN_LETTER, 5'd0, 31'd0);
      offer(OP_TRAIN_END, 5'd0, 31'd0);
      offer(OP_SAMPLE, 5'd0, 31'd0);
      offer(OP_SAMPLE, 5'd0, 31'h7FFF_FFFF);
      offer(OP_SAMPLE, 5'd0, 31'd1);
      offer(OP_TRAIN_END, 5'd0, 31'd0);
      offer(OP_SAMPLE, 5'd0, 31'd2);
      offer(OP_SAMPLE, 5'd0, 31'h4000_0000);
      drain_responses();

      // Deepen the last row: a long run of one letter piles up in one context.
      gaps_on = 1'b0;
      for (int k = 0; k < 300; k++) offer(OP_TRAIN_LETTER, 5'd0, 31'($urandom));
      offer(OP_TRAIN_END, 5'd0, 31'd0);
      for (int k = 0; k < 8; k++) offer(OP_SAMPLE, 5'd0, 31'($urandom));
      drain_responses();

      // Random words: first a stretch without gaps, then with them.
      for (int n = 0; n < 120; n++) begin
         if (n == 25) gaps_on = 1'b1;
         if (n == 50) hold_off_due = 1'b1;
         if (n == 60) drain_responses();
         offer_word();
      end
      drain_responses();
      repeat (100) @(posedge clock);

      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
hdl/ptcm_pkg.sv
hdl/ptcm_if.sv
hdl/ptcm_ram.sv
hdl/ptcm_mod_unit.sv
hdl/position_trigram_char_model.sv
verif/ptcm_checker.sv
verif/position_trigram_char_model_test.sv
